// ===== rtl/sha256_byte_stream_hasher_unit_assert.svh =====
// Assertion macros for the SHA-256 byte stream hasher.
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_ASSERT_SVH
// Assert an implication on every clock edge outside reset.
`define SHA_ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Assert a condition that must hold at every clock edge, reset included.
`define SHA_ASSERT_ALWAYS(label, clk, cond, msg) \
    label: assert property (@(posedge clk) cond) else $error(msg);
`endif

// ===== rtl/shabs_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
package shabs_pkg;

    localparam int unsigned QueueDepth = 4;

    typedef struct packed {
        logic       finish;
        logic [7:0] data;
    } shabs_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } shabs_state_t;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k [64];
        k = '{
            32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
            32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
            32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
            32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
            32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
            32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
            32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
            32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
            32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
            32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
            32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
            32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
            32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
            32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
            32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
            32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
        };
        return k[r];
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] h [8];
        h = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
              32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};
        return h[i];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== rtl/sha256_byte_stream_hasher_unit.sv =====
// SHA-256 byte stream hasher top level.
// Usage:
//  s_ channel: one transaction per message byte (tuser=0, tdata=byte) or a
//  finish (tuser=1). Bytes are gathered into 64-byte blocks; each full block
//  is compressed by a single round unit, one round per cycle.
//  m_ channel: a finish yields four transactions, tdata = 64 digest bits,
//  tuser = word index, tlast on the fourth word.
//  Input: bytes are taken at one per cycle into a four-entry queue while it
//  has room; a full block holds the round unit for a load, 64 rounds and a
//  fold, and no byte leaves the queue until that block is done.
//  Finish: with the queue empty, the finish is popped, then the padded block
//  is loaded, runs 64 rounds and is folded, and all of that once more when
//  the length needs an extra block; then one word per cycle while m_tready is high.
//  Reset (aresetn low, synchronous) empties the queue, restores the initial
//  hash values and clears byte and bit counts.
//  When the receiver stalls, the digest word holds and the queue fills, then
//  s_tready drops.
module sha256_byte_stream_hasher_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // digest_word[63:0]
    output logic [1:0]  m_tuser,   // word_index[1:0]
    output logic        m_tlast    // last_word
);
    import shabs_pkg::*;

    shabs_item_t q_item;
    logic        q_valid, q_pop;

    shabs_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready,
        .s_op(s_tuser), .s_byte(s_tdata),
        .q_valid, .q_pop, .q_item
    );

    shabs_core u_core (
        .aclk, .aresetn, .q_valid, .q_pop, .q_item,
        .m_tvalid, .m_tready,
        .m_word(m_tdata), .m_index(m_tuser), .m_last(m_tlast)
    );
endmodule

// ===== rtl/shabs_front.sv =====
// Input side: accepts byte/finish transactions into a short queue.
module shabs_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_op,
    input  logic [7:0]            s_byte,
    output logic                  q_valid,
    input  logic                  q_pop,
    output shabs_pkg::shabs_item_t q_item
);
    import shabs_pkg::*;
    `include "sha256_byte_stream_hasher_unit_assert.svh"

    localparam int unsigned PtrW = $clog2(QueueDepth);

    shabs_item_t           mem_reg [QueueDepth];
    logic [PtrW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]         count_reg;
    logic                  push;

    assign s_tready = (count_reg != (PtrW+1)'(QueueDepth));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= '{finish: s_op, data: s_byte};
        end
    end

    // Pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (q_pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
        end
    end

    `SHA_ASSERT_IMPL(a_no_pop_empty, aclk, aresetn, q_pop |-> q_valid, "pop from empty queue")
    `SHA_ASSERT_IMPL(a_count_range, aclk, aresetn,
        count_reg <= (PtrW+1)'(QueueDepth), "queue count overflow")
    `SHA_ASSERT_IMPL(a_count_step, aclk, aresetn,
        (push && !q_pop) |=> count_reg == $past(count_reg) + 1'b1, "queue count slip")
endmodule

// ===== rtl/shabs_core.sv =====
// Back side: block window, padding, 64-round compression and digest output.
module shabs_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  shabs_pkg::shabs_item_t q_item,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_word,
    output logic [1:0]            m_index,
    output logic                  m_last
);
    import shabs_pkg::*;
    `include "sha256_byte_stream_hasher_unit_assert.svh"

    shabs_state_t   state_reg, state_next;
    logic [5:0]     fill_reg;
    logic [63:0]    bits_reg;
    logic [31:0]    h_reg [8];
    logic [31:0]    v_reg [8];
    logic [31:0]    w_reg [16];
    logic [5:0]     rnd_reg;
    logic           pad_reg;     // finish in progress
    logic           second_reg;  // extra length block in progress
    logic [1:0]     out_idx_reg;

    // Padding byte at a position
    function automatic logic [7:0] pad_byte(input logic [5:0] p, input logic [5:0] f,
                                            input logic sec, input logic [63:0] b,
                                            input logic [7:0] held);
        logic [7:0] r;
        if (sec) begin
            r = (p >= 6'd56) ? b[8*(63-p) +: 8] : 8'h00;
        end else if (p < f) begin
            r = held;
        end else if (p == f) begin
            r = 8'h80;
        end else if (p >= 6'd56 && f < 6'd56) begin
            r = b[8*(63-p) +: 8];
        end else begin
            r = 8'h00;
        end
        return r;
    endfunction

    logic [31:0] t1, t2, wn, wcur, s0, s1;
    logic [31:0] pad_win [16];

    always_comb begin
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        wn = s1 + w_reg[9] + s0 + w_reg[0];
        wcur = w_reg[0];
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25)) +
             ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + round_k(rnd_reg) + wcur;
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22)) +
             ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // Padded window: held bytes, 0x80 marker, zeros and the bit length
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            for (int j = 0; j < 4; j++) begin
                pad_win[i][8*(3-j) +: 8] = pad_byte(6'(4*i+j), fill_reg, second_reg,
                                                    bits_reg, w_reg[i][8*(3-j) +: 8]);
            end
        end
    end

    // Next state and handshakes
    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_item.finish) state_next = ST_LOAD;
                    else if (fill_reg == 6'd63) state_next = ST_LOAD;
                end
            end
            ST_LOAD:  state_next = ST_ROUND;
            ST_ROUND: if (rnd_reg == 6'd63) state_next = ST_FOLD;
            ST_FOLD: begin
                if (!pad_reg) state_next = ST_IDLE;
                else if (!second_reg && fill_reg >= 6'd56) state_next = ST_LOAD;
                else state_next = ST_EMIT;
            end
            ST_EMIT:  if (m_tready && out_idx_reg == 2'd3) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // Counters, working variables and chaining words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            bits_reg    <= '0;
            pad_reg     <= 1'b0;
            second_reg  <= 1'b0;
            out_idx_reg <= '0;
            rnd_reg     <= '0;
            for (int i = 0; i < 8; i++) h_reg[i] <= init_hash(3'(i));
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid && !q_item.finish) begin
                        fill_reg <= fill_reg + 1'b1;
                        bits_reg <= bits_reg + 64'd8;
                        pad_reg  <= 1'b0;
                    end else if (q_valid) begin
                        pad_reg     <= 1'b1;
                        second_reg  <= 1'b0;
                    end
                end
                ST_LOAD: begin
                    rnd_reg <= '0;
                    for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                end
                ST_ROUND: begin
                    rnd_reg <= rnd_reg + 1'b1;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                end
                ST_FOLD: begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                    if (pad_reg && !second_reg && fill_reg >= 6'd56) begin
                        second_reg  <= 1'b1;
                    end else begin
                        second_reg <= 1'b0;
                    end
                    if (!pad_reg) fill_reg <= '0;
                end
                ST_EMIT: begin
                    if (m_tready) begin
                        out_idx_reg <= out_idx_reg + 1'b1;
                        if (out_idx_reg == 2'd3) begin
                            for (int i = 0; i < 8; i++) h_reg[i] <= init_hash(3'(i));
                            fill_reg <= '0;
                            bits_reg <= '0;
                            pad_reg  <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Schedule window: bytes land in place, padding fills it at load, rounds roll it
    always_ff @(posedge aclk) begin
        if (state_reg == ST_ROUND) begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wn;
        end else if (state_reg == ST_LOAD && pad_reg) begin
            for (int i = 0; i < 16; i++) w_reg[i] <= pad_win[i];
        end else if (state_reg == ST_IDLE && q_valid && !q_item.finish) begin
            // big-endian within words
            w_reg[fill_reg[5:2]][8*(3-fill_reg[1:0]) +: 8] <= q_item.data;
        end
    end

    // Digest output
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_word   = {h_reg[{out_idx_reg, 1'b0}], h_reg[{out_idx_reg, 1'b1}]};
    assign m_index  = out_idx_reg;
    assign m_last   = (out_idx_reg == 2'd3);

    `SHA_ASSERT_IMPL(a_emit_hold, aclk, aresetn,
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(out_idx_reg), "digest word dropped")
    `SHA_ASSERT_IMPL(a_pop_idle, aclk, aresetn, q_pop |-> state_reg == ST_IDLE, "pop while busy")
    `SHA_ASSERT_IMPL(a_round_end, aclk, aresetn,
        (state_reg == ST_ROUND && rnd_reg == 6'd63) |=> state_reg == ST_FOLD, "round count slip")
endmodule

// ===== tb/tb_sha256_byte_stream_hasher_unit.sv =====
// Self-checking testbench for the SHA-256 byte stream hasher unit.
module tb_sha256_byte_stream_hasher_unit;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [63:0] word;
        logic [1:0]  index;
        logic        last;
    } digest_beat_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // predictor state
    logic [31:0]  hash_state [8];
    logic [7:0]   byte_buffer [64];
    int unsigned  buffer_fill;
    logic [63:0]  bit_length;
    digest_beat_t pending_digests [$];

    int unsigned mismatch_count;
    int unsigned digest_beats_seen;
    int unsigned items_sent;
    int unsigned messages_sent;
    int unsigned cycle_count;
    bit          hold_off;
    bit          burst_mode;

    sha256_byte_stream_hasher_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] start_hash(input int i);
        logic [31:0] iv [8];
        iv = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
               32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};
        return iv[i];
    endfunction

    function automatic logic [31:0] round_const(input int r);
        logic [31:0] kc [64];
        kc = '{
            32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
            32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
            32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
            32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
            32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
            32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
            32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
            32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
            32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
            32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
            32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
            32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
            32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
            32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
            32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
            32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
        };
        return kc[r];
    endfunction

    // Fold the 64-byte buffer into the running hash state.
    task automatic compress_buffer();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {byte_buffer[4*i], byte_buffer[4*i+1], byte_buffer[4*i+2],
                    byte_buffer[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        v = hash_state;
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
                 ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const(r) + w[r];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
                 ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] += v[i];
    endtask

    task automatic reset_hash();
        for (int i = 0; i < 8; i++)
            hash_state[i] = start_hash(i);
        buffer_fill = 0;
        bit_length  = '0;
    endtask

    // Update the predictor with one accepted transaction.
    task automatic predict_digest(input logic op, input logic [7:0] data);
        digest_beat_t beat;
        int unsigned pos;
        if (op == OP_ABSORB) begin
            byte_buffer[buffer_fill] = data;
            bit_length += 64'd8;
            buffer_fill = (buffer_fill + 1) % 64;
            if (buffer_fill == 0)
                compress_buffer();
            return;
        end
        pos = buffer_fill;
        byte_buffer[pos++] = 8'h80;
        if (pos > 56) begin
            while (pos < 64)
                byte_buffer[pos++] = 8'h00;
            compress_buffer();
            pos = 0;
        end
        while (pos < 56)
            byte_buffer[pos++] = 8'h00;
        for (int i = 0; i < 8; i++)
            byte_buffer[56 + i] = bit_length[63 - 8*i -: 8];
        compress_buffer();
        for (int k = 0; k < 4; k++) begin
            beat.word  = {hash_state[2*k], hash_state[2*k+1]};
            beat.index = 2'(k);
            beat.last  = (k == 3);
            pending_digests.push_back(beat);
        end
        reset_hash();
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    // Offer one transaction, with random gaps unless bursting.
    task automatic send_item(input logic op, input logic [7:0] data);
        if (!burst_mode && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        predict_digest(op, data);
        items_sent++;
        if (op == OP_FINISH)
            messages_sent++;
    endtask

    task automatic send_message(input int unsigned len, input bit pattern,
                                input logic [7:0] fill);
        for (int i = 0; i < len; i++)
            send_item(OP_ABSORB, pattern ? fill : 8'($urandom_range(0, 255)));
        send_item(OP_FINISH, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_digests.size() != 0)
            @(posedge aclk);
    endtask

    // Empty message, then the FIPS "abc" vector.
    task automatic test_known_vectors();
        send_item(OP_FINISH, 8'hFF);
        send_item(OP_ABSORB, 8'h61);
        send_item(OP_ABSORB, 8'h62);
        send_item(OP_ABSORB, 8'h63);
        send_item(OP_FINISH, 8'h00);
    endtask

    // 120 bytes: a full block by absorb, then 56 held bytes force an extra block.
    task automatic test_block_boundaries();
        burst_mode = ($urandom_range(0, 1) == 0);
        send_message(120, 1'b0, 8'h00);
        burst_mode = 1'b0;
    endtask

    // Receiver holds off while transactions keep coming, so the input must stall.
    task automatic test_backpressure();
        hold_off   = 1'b1;
        burst_mode = 1'b1;
        send_item(OP_FINISH, 8'h00);
        send_message(2, 1'b1, 8'hFF);
        send_item(OP_FINISH, 8'h00);
        send_item(OP_FINISH, 8'h00);
        burst_mode = 1'b0;
        wait_drained();
    endtask

    // Receiver stall pattern, with a long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 15) < 11) || (cycle_count[9:8] == 2'b01);
    end

    initial begin
        hold_off = 1'b0;
        wait (aresetn);
        forever begin
            wait (hold_off);
            repeat (400) @(posedge aclk);
            hold_off = 1'b0;
        end
    end

    // Check each digest transaction against the oldest prediction.
    always @(posedge aclk) begin
        digest_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            digest_beats_seen++;
            if (pending_digests.size() == 0) begin
                report_mismatch("unexpected digest beat", m_tdata, 64'd0);
            end else begin
                want = pending_digests.pop_front();
                if (m_tdata !== want.word)
                    report_mismatch("digest word", m_tdata, want.word);
                if (m_tuser !== want.index)
                    report_mismatch("word index", 64'(m_tuser), 64'(want.index));
                if (m_tlast !== want.last)
                    report_mismatch("last flag", 64'(m_tlast), 64'(want.last));
            end
        end
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d digest beats outstanding", pending_digests.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        cycle_count       = 0;
        mismatch_count    = 0;
        digest_beats_seen = 0;
        items_sent        = 0;
        messages_sent     = 0;
        burst_mode        = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= OP_ABSORB;
        s_tdata  <= 8'h00;
        reset_hash();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_known_vectors();
        test_block_boundaries();
        test_backpressure();

        wait_drained();
        repeat (200) @(posedge aclk);
        $display("covered %0d transactions in %0d messages, %0d digest beats checked",
                 items_sent, messages_sent, digest_beats_seen);
        $display("including empty, two-block padded and back-pressured messages");
        if (mismatch_count == 0 && pending_digests.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
